[hdl/rhr_pkg.sv]
// ----------------------------------------------------------------------------
// rhr_pkg
// Shared constants, register codes and hue helpers for the random HLS to RGB
// color block.
// ----------------------------------------------------------------------------
package rhr_pkg;

    // hue arithmetic, degrees
    localparam int HUE_W      = 9;
    localparam int HUE_SUM_W  = HUE_W + 1;
    localparam int RAMP_W     = 6;
    localparam int RGB_W      = 8;

    localparam logic [HUE_W-1:0]  HUE_MOD      = 9'd360;
    localparam logic [HUE_W-1:0]  HUE_THIRD    = 9'd120;
    localparam logic [HUE_W-1:0]  HUE_TWO_THRD = 9'd240;
    localparam logic [HUE_W-1:0]  HUE_RISE_END = 9'd60;
    localparam logic [HUE_W-1:0]  HUE_FLAT_END = 9'd180;
    localparam logic [RAMP_W-1:0] RAMP_LEN     = 6'd60;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LIGHTNESS  = 3'd0,
        CFG_MAX_LIGHTNESS  = 3'd1,
        CFG_MIN_SATURATION = 3'd2,
        CFG_MAX_SATURATION = 3'd3,
        CFG_FIXED_HUE      = 3'd4
    } t_cfg_idx;

    // reduce a 9-bit hue (0..511) into 0..359
    function automatic logic [HUE_W-1:0] hue_wrap9(input logic [HUE_W-1:0] h);
        logic [HUE_W-1:0] r;
        r = (h >= HUE_MOD) ? h - HUE_MOD : h;
        return r;
    endfunction

    // add an offset to a hue in 0..359 and wrap back into 0..359
    function automatic logic [HUE_W-1:0] hue_shift(input logic [HUE_W-1:0] h,
                                                   input logic [HUE_W-1:0] ofs);
        logic [HUE_SUM_W-1:0] s;
        logic [HUE_SUM_W-1:0] w;
        s = {1'b0, h} + {1'b0, ofs};
        w = (s >= {1'b0, HUE_MOD}) ? s - {1'b0, HUE_MOD} : s;
        return w[HUE_W-1:0];
    endfunction

    // ramp weight in 0..60 for a channel hue in 0..359
    function automatic logic [RAMP_W-1:0] ramp_weight(input logic [HUE_W-1:0] h);
        logic [HUE_W-1:0] fall;
        logic [RAMP_W-1:0] t;
        fall = HUE_TWO_THRD - h;
        if (h < HUE_RISE_END) begin
            t = h[RAMP_W-1:0];
        end else if (h < HUE_FLAT_END) begin
            t = RAMP_LEN;
        end else if (h < HUE_TWO_THRD) begin
            t = fall[RAMP_W-1:0];
        end else begin
            t = '0;
        end
        return t;
    endfunction

endpackage

[hdl/rhr_in_if.sv]
// ----------------------------------------------------------------------------
// rhr_in_if
// Input channel: one item carries a drawn hue and two random fractions.
// ----------------------------------------------------------------------------
interface rhr_in_if #(
    parameter int FRACTION_BITS = 15
);
    logic                     valid;
    logic                     ready;
    logic [8:0]               drawn_hue;
    logic [FRACTION_BITS-1:0] lightness_draw;
    logic [FRACTION_BITS-1:0] saturation_draw;

    modport source (output valid, output drawn_hue, output lightness_draw,
                    output saturation_draw, input ready);
    modport sink   (input valid, input drawn_hue, input lightness_draw,
                    input saturation_draw, output ready);
endinterface

[hdl/rhr_out_if.sv]
// ----------------------------------------------------------------------------
// rhr_out_if
// Output channel: one item carries an 8-bit RGB color.
// ----------------------------------------------------------------------------
interface rhr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input red, input green, input blue,
                    output ready);
endinterface

[hdl/rhr_cfg.sv]
// ----------------------------------------------------------------------------
// rhr_cfg
// Configuration registers. Bounds are stored already limited to one, the
// fixed hue already reduced modulo 360 with its sign kept as a select flag.
// ----------------------------------------------------------------------------
module rhr_cfg #(
    parameter int FRACTION_BITS = 15
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [rhr_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [((FRACTION_BITS + 1 > 10) ? FRACTION_BITS + 1 : 10)-1:0] i_cfg_data,
    output logic [FRACTION_BITS:0]                 o_min_l,
    output logic [FRACTION_BITS:0]                 o_max_l,
    output logic [FRACTION_BITS:0]                 o_min_s,
    output logic [FRACTION_BITS:0]                 o_max_s,
    output logic                                   o_use_drawn,
    output logic [rhr_pkg::HUE_W-1:0]              o_fixed_hue
);
    import rhr_pkg::*;

    localparam int W = FRACTION_BITS + 1;
    localparam logic [W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [HUE_W-1:0] HUE_RST = 9'h1FF - HUE_MOD;

    logic [W-1:0]     r_min_l, r_max_l, r_min_s, r_max_s;
    logic             r_use_drawn;
    logic [HUE_W-1:0] r_fixed_hue;
    logic [W-1:0]     bound;
    logic [W-1:0]     raw;

    // bound written above one is kept as one
    assign raw   = i_cfg_data[W-1:0];
    assign bound = (raw > ONE) ? ONE : raw;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_l     <= '0;
            r_max_l     <= ONE;
            r_min_s     <= '0;
            r_max_s     <= ONE;
            r_use_drawn <= 1'b1;
            r_fixed_hue <= HUE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_LIGHTNESS:  r_min_l <= bound;
                CFG_MAX_LIGHTNESS:  r_max_l <= bound;
                CFG_MIN_SATURATION: r_min_s <= bound;
                CFG_MAX_SATURATION: r_max_s <= bound;
                CFG_FIXED_HUE: begin
                    r_use_drawn <= i_cfg_data[HUE_W];
                    r_fixed_hue <= hue_wrap9(i_cfg_data[HUE_W-1:0]);
                end
                default: ;
            endcase
        end
    end

    assign o_min_l     = r_min_l;
    assign o_max_l     = r_max_l;
    assign o_min_s     = r_min_s;
    assign o_max_s     = r_max_s;
    assign o_use_drawn = r_use_drawn;
    assign o_fixed_hue = r_fixed_hue;

endmodule

[hdl/random_hls_to_rgb_color.sv]
// ----------------------------------------------------------------------------
// random_hls_to_rgb_color
// Turns random draws into an 8-bit RGB color through HLS with configured
// lightness and saturation bounds and an optional fixed hue.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  i_in      in    valid/ready    drawn_hue, lightness_draw, saturation_draw
//  o_out     out   valid/ready    red, green, blue
//  cfg       in    i_cfg_we       i_cfg_idx, i_cfg_data (write only)
//
//  Six register stages: place bounds, finish L/S, p2 product, p1/p2,
//  ramp sums, output register. One item per cycle while the output is not stalled.
//  Each stage advances when it is empty or the stage after it advances,
//  so bubbles close up and a stalled output holds its item.
//  Synchronous active-low reset clears all valid bits and loads the
//  configuration defaults; the data registers are not reset.
// ----------------------------------------------------------------------------
module random_hls_to_rgb_color #(
    parameter int FRACTION_BITS = 15
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    rhr_in_if.sink                                 i_in,
    rhr_out_if.source                              o_out,
    input  logic                                   i_cfg_we,
    input  logic [rhr_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [((FRACTION_BITS + 1 > 10) ? FRACTION_BITS + 1 : 10)-1:0] i_cfg_data
);
    import rhr_pkg::*;

    localparam int F      = FRACTION_BITS;
    localparam int W      = F + 1;
    localparam int PROD_W = 2 * F + 3;
    localparam int NUM_W  = F + 7;
    localparam int VAL_W  = NUM_W + 4;
    localparam int NSTG   = 5;
    localparam logic [W-1:0] ONE  = {1'b1, {F{1'b0}}};
    localparam logic [W-1:0] HALF = {2'b01, {(F-1){1'b0}}};

    // configuration
    logic [W-1:0]     min_l, max_l, min_s, max_s;
    logic             use_drawn;
    logic [HUE_W-1:0] fixed_hue;

    rhr_cfg #(.FRACTION_BITS(F)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_min_l     (min_l),
        .o_max_l     (max_l),
        .o_min_s     (min_s),
        .o_max_s     (max_s),
        .o_use_drawn (use_drawn),
        .o_fixed_hue (fixed_hue)
    );

    // stage control
    logic [NSTG-1:0] r_v;
    logic            r_ov;
    logic [NSTG:0]   en;

    always_comb begin
        en[NSTG] = !r_ov || o_out.ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_in.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else begin
            if (en[0]) r_v[0] <= i_in.valid;
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
            if (en[NSTG]) r_ov <= r_v[NSTG-1];
        end
    end

    // stage 1: bound spans times draws, hue select
    logic signed [F+1:0]     span_l, span_s;
    logic signed [PROD_W-1:0] n1_prod_l, n1_prod_s;
    logic [F-1:0]            draw_l, draw_s;
    logic [HUE_W-1:0]        n1_hue;
    logic signed [PROD_W-1:0] r1_prod_l, r1_prod_s;
    logic [HUE_W-1:0]        r1_hue;

    assign draw_l    = i_in.lightness_draw;
    assign draw_s    = i_in.saturation_draw;
    assign span_l    = $signed({1'b0, max_l}) - $signed({1'b0, min_l});
    assign span_s    = $signed({1'b0, max_s}) - $signed({1'b0, min_s});
    assign n1_prod_l = $signed({1'b0, draw_l}) * span_l;
    assign n1_prod_s = $signed({1'b0, draw_s}) * span_s;
    assign n1_hue    = use_drawn ? hue_wrap9(i_in.drawn_hue) : fixed_hue;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_prod_l <= n1_prod_l;
            r1_prod_s <= n1_prod_s;
            r1_hue    <= n1_hue;
        end
    end

    // stage 2: L and S (floor of the scaled product), channel hues
    logic signed [PROD_W-1:0] l_wide, s_wide;
    logic [W-1:0]            r2_l, r2_s;
    logic [HUE_W-1:0]        r2_hue [3];

    assign l_wide = $signed({{(F+2){1'b0}}, min_l}) + (r1_prod_l >>> F);
    assign s_wide = $signed({{(F+2){1'b0}}, min_s}) + (r1_prod_s >>> F);

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_l      <= l_wide[W-1:0];
            r2_s      <= s_wide[W-1:0];
            r2_hue[0] <= hue_shift(r1_hue, HUE_THIRD);
            r2_hue[1] <= r1_hue;
            r2_hue[2] <= hue_shift(r1_hue, HUE_TWO_THRD);
        end
    end

    // stage 3: L*(S+1) or L*S, ramp weights
    logic              n3_low;
    logic [W:0]        mul_op;
    logic [PROD_W-1:0] n3_m;
    logic [PROD_W-1:0] r3_m;
    logic              r3_low;
    logic [W-1:0]      r3_l, r3_s;
    logic [RAMP_W-1:0] r3_t [3];

    assign n3_low = (r2_l <= HALF);
    assign mul_op = n3_low ? ({1'b0, r2_s} + {1'b0, ONE}) : {1'b0, r2_s};
    assign n3_m   = PROD_W'(r2_l) * PROD_W'(mul_op);

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_m   <= n3_m;
            r3_low <= n3_low;
            r3_l   <= r2_l;
            r3_s   <= r2_s;
            for (int c = 0; c < 3; c++) begin
                r3_t[c] <= ramp_weight(r2_hue[c]);
            end
        end
    end

    // stage 4: p2, p1 and the ramp height p2 - p1
    logic [F+2:0]      mq, p2_alt, p2_w;
    logic [W-1:0]      n4_p2;
    logic [W:0]        p1_w;
    logic [W-1:0]      r4_p1, r4_d;
    logic [RAMP_W-1:0] r4_t [3];

    assign mq     = r3_m[PROD_W-1:F];
    assign p2_alt = {2'b00, r3_l} + {2'b00, r3_s} - mq;
    assign p2_w   = r3_low ? mq : p2_alt;
    assign n4_p2  = p2_w[W-1:0];
    assign p1_w   = {r3_l, 1'b0} - {1'b0, n4_p2};

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_p1 <= p1_w[W-1:0];
            r4_d  <= n4_p2 - p1_w[W-1:0];
            r4_t  <= r3_t;
        end
    end

    // stage 5: 60*p1 + (p2-p1)*t per channel
    logic [NUM_W-1:0] r5_num [3];

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            for (int c = 0; c < 3; c++) begin
                r5_num[c] <= NUM_W'(r4_p1) * NUM_W'(RAMP_LEN)
                           + NUM_W'(r4_d) * NUM_W'(r4_t[c]);
            end
        end
    end

    // output register: floor(255*num / (60*ONE)) = floor(17*num / (4*ONE))
    logic [VAL_W-1:0] val [3];
    logic [RGB_W-1:0] r_rgb [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            val[c] = {r5_num[c], 4'b0000} + {4'b0000, r5_num[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NSTG]) begin
            for (int c = 0; c < 3; c++) begin
                r_rgb[c] <= val[c][F+9:F+2];
            end
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.red   = r_rgb[0];
    assign o_out.green = r_rgb[1];
    assign o_out.blue  = r_rgb[2];

`ifndef SYNTHESIS
    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid && (r_v == '0))
        else $error("pipeline not empty after reset");

    // full pipeline with stalled output refuses new items
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready && (&r_v)) |-> !i_in.ready)
        else $error("item taken while pipeline full");

    // p2 never exceeds one
    a_p2_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] |-> (({1'b0, r4_p1} + {1'b0, r4_d}) <= {1'b0, ONE}))
        else $error("p2 above one");

    // ramp sums stay within 60*ONE so the channel fits 8 bits
    a_num_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[4] |-> (r5_num[0] <= NUM_W'(ONE) * NUM_W'(RAMP_LEN)) &&
                   (r5_num[1] <= NUM_W'(ONE) * NUM_W'(RAMP_LEN)) &&
                   (r5_num[2] <= NUM_W'(ONE) * NUM_W'(RAMP_LEN)))
        else $error("ramp sum out of range");

    // a stalled ramp-sum stage keeps its item
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NSTG-1] && !en[NSTG-1]) |=> r_v[NSTG-1] && $stable(r5_num[1]))
        else $error("stalled item lost");
`endif

endmodule
